// ===== rtl/sots_pkg.sv =====
// ----------------------------------------------------------------------------
// Sum of two squares test - shared definitions
// Widths, derived constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sots_pkg;

   // Width of the number under test (bits of the input word that are used)
   localparam int NUM_WIDTH  = 16;
   // Width of the input field on the port
   localparam int IN_WIDTH   = 16;
   // Width of each root field on the port
   localparam int OUT_ROOT_WIDTH = 8;

   // Half width, rounded up: a root of a NUM_WIDTH number fits in HALF_WIDTH bits
   localparam int HALF_WIDTH = (NUM_WIDTH + 1) / 2;
   // The first root may step one past the largest root, hence one bit more
   localparam int ROOT_WIDTH = HALF_WIDTH + 1;
   // Squares and their sum, with headroom for the overshoot
   localparam int SQ_WIDTH   = 2 * HALF_WIDTH + 2;

   // Starting value of the second root and its square
   localparam longint unsigned B_INIT_L = (64'd1 << HALF_WIDTH) - 64'd1;
   localparam logic [ROOT_WIDTH-1:0] B_INIT    = ROOT_WIDTH'(B_INIT_L);
   localparam logic [SQ_WIDTH-1:0]   B_SQ_INIT = SQ_WIDTH'(B_INIT_L * B_INIT_L);

   // Mask that keeps the low NUM_WIDTH bits of the number
   localparam logic [SQ_WIDTH-1:0] NUM_MASK =
      {{(SQ_WIDTH - NUM_WIDTH){1'b0}}, {NUM_WIDTH{1'b1}}};

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;   // load a new number and restart the search
      logic step;    // advance the search by one move
      logic load;    // capture the outcome in the result register
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic done;    // the search has reached a decision
      logic hit;     // the decision is a decomposition
   } ctl_status_type;

endpackage

`default_nettype wire

// ===== rtl/sots_datapath.sv =====
// ----------------------------------------------------------------------------
// Sum of two squares test - datapath
// Two-pointer search: a climbs from 1, b falls from the top root, with both
// squares kept up to date by additions and subtractions only. Holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sots_datapath
   import sots_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic [IN_WIDTH-1:0]       number,
   input  wire ctl_cmd_type               cmd,
   output      ctl_status_type            status,
   output      logic                      found,
   output      logic [OUT_ROOT_WIDTH-1:0] first_root,
   output      logic [OUT_ROOT_WIDTH-1:0] second_root
);

   logic [SQ_WIDTH-1:0]   n_ff,    n_in;
   logic [ROOT_WIDTH-1:0] a_ff,    a_in;
   logic [ROOT_WIDTH-1:0] b_ff,    b_in;
   logic [SQ_WIDTH-1:0]   a_sq_ff, a_sq_in;
   logic [SQ_WIDTH-1:0]   b_sq_ff, b_sq_in;

   logic                       found_ff,  found_in;
   logic [OUT_ROOT_WIDTH-1:0]  first_ff,  first_in;
   logic [OUT_ROOT_WIDTH-1:0]  second_ff, second_in;

   logic [SQ_WIDTH-1:0]   sum;
   logic                  a_past;
   logic                  b_zero;
   logic                  sum_eq;
   logic                  sum_gt;
   logic [ROOT_WIDTH+OUT_ROOT_WIDTH-1:0] a_wide;
   logic [ROOT_WIDTH+OUT_ROOT_WIDTH-1:0] b_wide;

   // Decision for the current pair
   always_comb begin
      sum    = a_sq_ff + b_sq_ff;
      a_past = (a_sq_ff >= n_ff);
      b_zero = (b_ff == '0);
      sum_eq = (sum == n_ff);
      sum_gt = (sum > n_ff);
      status.done = a_past || b_zero || sum_eq;
      status.hit  = sum_eq && !a_past && !b_zero;
   end

   // Search registers: load on start, move one pointer on step
   always_comb begin
      n_in    = n_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      a_sq_in = a_sq_ff;
      b_sq_in = b_sq_ff;
      if (cmd.start) begin
         n_in    = SQ_WIDTH'(number) & NUM_MASK;
         a_in    = ROOT_WIDTH'(1);
         a_sq_in = SQ_WIDTH'(1);
         b_in    = B_INIT;
         b_sq_in = B_SQ_INIT;
      end else if (cmd.step && !status.done) begin
         if (sum_gt) begin
            // (b-1)^2 = b^2 - (2b - 1)
            b_in    = b_ff - ROOT_WIDTH'(1);
            b_sq_in = b_sq_ff - SQ_WIDTH'({b_ff - ROOT_WIDTH'(1), 1'b1});
         end else begin
            // (a+1)^2 = a^2 + 2a + 1
            a_in    = a_ff + ROOT_WIDTH'(1);
            a_sq_in = a_sq_ff + SQ_WIDTH'({a_ff, 1'b1});
         end
      end
   end

   // Result word: roots are cleared when nothing is found
   always_comb begin
      a_wide    = {{OUT_ROOT_WIDTH{1'b0}}, a_ff};
      b_wide    = {{OUT_ROOT_WIDTH{1'b0}}, b_ff};
      found_in  = found_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (cmd.load) begin
         found_in  = status.hit;
         first_in  = status.hit ? a_wide[OUT_ROOT_WIDTH-1:0] : '0;
         second_in = status.hit ? b_wide[OUT_ROOT_WIDTH-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      a_sq_ff   <= a_sq_in;
      b_sq_ff   <= b_sq_in;
      found_ff  <= found_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign found       = found_ff;
   assign first_root  = first_ff;
   assign second_root = second_ff;

endmodule

`default_nettype wire

// ===== rtl/sots_controller.sv =====
// ----------------------------------------------------------------------------
// Sum of two squares test - controller
// Sequences one word through the search and owns the handshakes of both
// channels, including the result slot that frees the search early.
// ----------------------------------------------------------------------------
`default_nettype none

module sots_controller
   import sots_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ctl_status_type  status,
   output      ctl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.start = 1'b0;
      cmd.step  = 1'b0;
      cmd.load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.done) begin
               if (slot_free) begin
                  cmd.load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            // decision is frozen; wait for the result slot
            if (slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sum_of_two_squares_test_core.sv =====
// ----------------------------------------------------------------------------
// Sum of two squares test - top level
// Decides whether a number is a*a + b*b with a, b >= 1 and returns the
// smallest such a with its b.
// ----------------------------------------------------------------------------
// Flow: the word is loaded, then the search makes one move per cycle until it
//   reaches a decision, then the result is loaded into the output register once the slot is free.
// Throughput: one word at a time; the next word is taken as soon as the result
//   is in the output register.
// Reset: synchronous, active high; clears the controller and the result valid.
`default_nettype none

module sum_of_two_squares_test_core
   import sots_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] number
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata    // [0] found, [8:1] first_root,
                                         // [16:9] second_root, [23:17] zero
);

   ctl_cmd_type               cmd;
   ctl_status_type            status;
   logic                      found;
   logic [OUT_ROOT_WIDTH-1:0] first_root;
   logic [OUT_ROOT_WIDTH-1:0] second_root;

   sots_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sots_datapath u_datapath (
      .clock       (clock),
      .number      (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .found       (found),
      .first_root  (first_root),
      .second_root (second_root)
   );

   // Pack the result word
   assign rsp_tdata = {7'd0, second_root, first_root, found};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sum of two squares test - testbench
// Streams numbers into the core and checks each result word against a
// behavioural search for the smallest decomposition a*a + b*b. It runs a
// directed set of edge values first, then random numbers that are biased
// towards decomposable values, squares and the ends of the range. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
   import sots_pkg::*;
;

   // Result word as it appears on rsp_tdata, lowest field last
   typedef struct packed {
      logic [6:0] pad;
      logic [7:0] second_root;
      logic [7:0] first_root;
      logic       found;
   } root_pair_type;

   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 5000000;
   localparam int MAX_REPORTS  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   logic [15:0]   number_q[$];
   root_pair_type expected_q[$];

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned numbers_sent  = 0;
   int unsigned results_seen  = 0;
   int unsigned found_count   = 0;
   int unsigned idle_left     = 0;
   int unsigned stall_left    = 0;
   int unsigned total_items   = 0;
   bit          drv_quiet     = 1'b0;
   bit          mon_quiet     = 1'b0;

   sum_of_two_squares_test_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] number
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [0] found, [8:1] first_root,
                                  // [16:9] second_root, [23:17] zero
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Floor square root, one result bit at a time from the top
   function automatic logic [31:0] floor_root(input logic [31:0] v);
      logic [31:0] r;
      logic [31:0] cand;
      r = '0;
      for (int i = 15; i >= 0; i--) begin
         cand = r | (32'd1 << i);
         if (64'(cand) * 64'(cand) <= 64'(v))
            r = cand;
      end
      return r;
   endfunction

   // Smallest a >= 1 with n - a*a a non-zero perfect square
   function automatic root_pair_type search_decomp(input logic [15:0] word);
      root_pair_type res;
      logic [31:0]   n;
      logic [31:0]   rem;
      logic [31:0]   r;
      n   = 32'(word) & ((32'd1 << NUM_WIDTH) - 32'd1);
      res = '0;
      for (logic [31:0] a = 1; a * a < n && !res.found; a++) begin
         rem = n - a * a;
         r   = floor_root(rem);
         if (r * r == rem && r != 0) begin
            res.found       = 1'b1;
            res.first_root  = a[7:0];
            res.second_root = r[7:0];
         end
      end
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned gap_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)      return 0;
      else if (pick < 85) return $urandom_range(1, 3);
      else if (pick < 97) return $urandom_range(4, 16);
      else                return $urandom_range(40, 250);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Request driver: hold the word until taken, then the next after a gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(search_decomp(req_tdata));
            numbers_sent++;
            if (numbers_sent % 64 == 0)
               drv_quiet = ($urandom_range(0, 3) == 0);
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (number_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= number_q.pop_front();
               idle_left  = drv_quiet ? 0 : gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure
   always @(posedge clock) begin
      root_pair_type got;
      root_pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (results_seen % 64 == 0)
               mon_quiet = ($urandom_range(0, 3) == 0);
            if (expected_q.size() == 0) begin
               note_mismatch($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               want = expected_q.pop_front();
               if (want.found)
                  found_count++;
               if (got.found !== want.found || got.first_root !== want.first_root ||
                   got.second_root !== want.second_root || got.pad !== want.pad)
                  note_mismatch($sformatf(
                     "exp found=%0d a=%0d b=%0d pad=%h, got found=%0d a=%0d b=%0d pad=%h",
                     want.found, want.first_root, want.second_root, want.pad,
                     got.found, got.first_root, got.second_root, got.pad));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!mon_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = gap_len();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus, then wait for every result word
   initial begin
      int unsigned kind;
      int unsigned a;
      int unsigned b;
      // edge values: zero, one, the smallest sums, squares, the top of the range
      number_q.push_back(16'd0);
      number_q.push_back(16'd1);
      number_q.push_back(16'd2);
      number_q.push_back(16'd3);
      number_q.push_back(16'd4);
      number_q.push_back(16'd5);
      number_q.push_back(16'd25);
      number_q.push_back(16'd50);
      number_q.push_back(16'd65025);
      number_q.push_back(16'd65026);
      number_q.push_back(16'd32768);
      number_q.push_back(16'd65522);
      number_q.push_back(16'd65535);
      number_q.push_back(16'd65534);
      number_q.push_back(16'd65533);
      number_q.push_back(16'h8000);
      number_q.push_back(16'h7FFF);
      number_q.push_back(16'hAAAA);
      number_q.push_back(16'h5555);
      number_q.push_back(16'd9);
      number_q.push_back(16'd7);
      // random part, biased towards values that decompose
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            number_q.push_back(16'($urandom_range(0, 65535)));
         end else if (kind < 7) begin
            a = $urandom_range(1, 255);
            b = $urandom_range(1, floor_root(65535 - a * a));
            number_q.push_back(16'(a * a + b * b));
         end else if (kind == 7) begin
            number_q.push_back(16'($urandom_range(0, 100)));
         end else if (kind == 8) begin
            number_q.push_back(16'($urandom_range(65000, 65535)));
         end else begin
            a = $urandom_range(0, 255);
            number_q.push_back(16'(a * a));
         end
      end
      total_items = number_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every word sent must come back; the watchdog catches a hang
      while (results_seen < total_items)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (numbers_sent != total_items || expected_q.size() != 0)
         note_mismatch($sformatf("sent %0d of %0d words, %0d results missing",
                                 numbers_sent, total_items, expected_q.size()));

      $display("Checked %0d results for %0d numbers: %0d decomposable, %0d not",
               results_seen, numbers_sent, found_count, results_seen - found_count);
      $display("Mismatches: %0d, cycles used: %0d", mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sum_of_two_squares_test_core.f =====
rtl/sots_pkg.sv
rtl/sots_datapath.sv
rtl/sots_controller.sv
rtl/sum_of_two_squares_test_core.sv
tb/tb_top.sv
